[rtl/clc_pkg.sv]
// ----------------------------------------------------------------------------
// Combination lock controller package
// Shared types, register indexes and the 7-segment decode for the lock block.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int DIGIT_W      = 4;
    localparam int TIMER_W      = 16;
    localparam int BEEP_W       = 4;
    localparam int SEG_W        = 7;
    localparam int NUM_DISPLAYS = 3;
    localparam int BUTTON_W     = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DIGIT_ZERO = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DIGIT_ONE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DIGIT_TWO  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_TICKS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_TICKS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_BEEPS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOSE_BEEPS     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_BEEPS     = 3'd7;

    // Input word kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    // Confirm button position within the button word
    localparam int CONFIRM_BIT = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TONE  = 2'd1,
        PH_PAUSE = 2'd2
    } beep_phase_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] code_digit_zero;
        logic [DIGIT_W-1:0] code_digit_one;
        logic [DIGIT_W-1:0] code_digit_two;
        logic [TIMER_W-1:0] tone_ticks;
        logic [TIMER_W-1:0] pause_ticks;
        logic [BEEP_W-1:0]  open_beeps;
        logic [BEEP_W-1:0]  close_beeps;
        logic [BEEP_W-1:0]  alarm_beeps;
    } cfg_t;

    typedef struct packed {
        logic                    tone_on;
        logic                    lock_open;
        logic [NUM_DISPLAYS-1:0] display_enable;
        logic [SEG_W-1:0]        segments;
    } result_t;

    // Segment pattern for a decimal digit, A in the top bit; blank above nine.
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'b1111110;
            4'd1:    seg = 7'b0110000;
            4'd2:    seg = 7'b1101101;
            4'd3:    seg = 7'b1111001;
            4'd4:    seg = 7'b0110011;
            4'd5:    seg = 7'b1011011;
            4'd6:    seg = 7'b1011111;
            4'd7:    seg = 7'b1110000;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1111011;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

[rtl/clc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Combination lock configuration registers
// Holds the secret code, the beep timing and the beep counts.
// ----------------------------------------------------------------------------
module clc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [clc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]   wr_data,
    output clc_pkg::cfg_t                    cfg
);
    import clc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_CODE_DIGIT_ZERO: cfg_next.code_digit_zero = wr_data[DIGIT_W-1:0];
                CFG_CODE_DIGIT_ONE:  cfg_next.code_digit_one  = wr_data[DIGIT_W-1:0];
                CFG_CODE_DIGIT_TWO:  cfg_next.code_digit_two  = wr_data[DIGIT_W-1:0];
                CFG_TONE_TICKS:      cfg_next.tone_ticks      = wr_data[TIMER_W-1:0];
                CFG_PAUSE_TICKS:     cfg_next.pause_ticks     = wr_data[TIMER_W-1:0];
                CFG_OPEN_BEEPS:      cfg_next.open_beeps      = wr_data[BEEP_W-1:0];
                CFG_CLOSE_BEEPS:     cfg_next.close_beeps     = wr_data[BEEP_W-1:0];
                CFG_ALARM_BEEPS:     cfg_next.alarm_beeps     = wr_data[BEEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_digit_zero <= 4'd1;
            cfg_reg.code_digit_one  <= 4'd2;
            cfg_reg.code_digit_two  <= 4'd3;
            cfg_reg.tone_ticks      <= 16'd200;
            cfg_reg.pause_ticks     <= 16'd150;
            cfg_reg.open_beeps      <= 4'd2;
            cfg_reg.close_beeps     <= 4'd1;
            cfg_reg.alarm_beeps     <= 4'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/clc_core.sv]
// ----------------------------------------------------------------------------
// Combination lock core
// Lock state, digit entry, display scan and beep sequencer, one word a cycle while item_en is high.
// ----------------------------------------------------------------------------
module clc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_en,
    input  logic                            item_kind,
    input  logic [clc_pkg::BUTTON_W-1:0]    item_buttons,
    input  clc_pkg::cfg_t                   cfg,
    output clc_pkg::result_t                result
);
    import clc_pkg::*;

    logic [DIGIT_W-1:0]      digit_reg [NUM_DISPLAYS];
    logic [DIGIT_W-1:0]      digit_next [NUM_DISPLAYS];
    logic [BUTTON_W-1:0]     prev_buttons_reg, prev_buttons_next;
    logic                    open_reg, open_next;
    logic [1:0]              disp_index_reg, disp_index_next;
    logic [SEG_W-1:0]        seg_reg, seg_next;
    logic [NUM_DISPLAYS-1:0] enable_reg, enable_next;
    logic [BEEP_W-1:0]       beeps_left_reg, beeps_left_next;
    logic [TIMER_W-1:0]      timer_reg, timer_next;
    beep_phase_t             phase_reg, phase_next;
    logic                    tone_reg, tone_next;

    logic [BUTTON_W-1:0]     falls;
    logic [TIMER_W-1:0]      timer_inc;
    logic [1:0]              scan_idx;
    logic                    code_match;

    assign falls     = prev_buttons_reg & ~item_buttons;
    assign timer_inc = timer_reg + 16'd1;
    // Index three never occurs; it is treated as display zero.
    assign scan_idx  = (disp_index_reg > 2'd2) ? 2'd0 : disp_index_reg;

    always_comb begin
        for (int k = 0; k < NUM_DISPLAYS; k++) begin
            digit_next[k] = digit_reg[k];
        end
        prev_buttons_next = prev_buttons_reg;
        open_next         = open_reg;
        disp_index_next   = disp_index_reg;
        seg_next          = seg_reg;
        enable_next       = enable_reg;
        beeps_left_next   = beeps_left_reg;
        timer_next        = timer_reg;
        phase_next        = phase_reg;
        tone_next         = tone_reg;
        code_match        = 1'b0;

        if (item_en && item_kind == KIND_BUTTON) begin
            for (int k = 0; k < NUM_DISPLAYS; k++) begin
                if (falls[k]) begin
                    digit_next[k] = (digit_reg[k] >= 4'd9) ? 4'd0 : digit_reg[k] + 4'd1;
                end
            end
            // The comparison sees digits already stepped by this same sample.
            code_match = (digit_next[0] == cfg.code_digit_zero) &&
                         (digit_next[1] == cfg.code_digit_one) &&
                         (digit_next[2] == cfg.code_digit_two);
            if (falls[CONFIRM_BIT]) begin
                if (code_match) begin
                    open_next       = ~open_reg;
                    timer_next      = '0;
                    phase_next      = PH_IDLE;
                    beeps_left_next = open_reg ? cfg.close_beeps : cfg.open_beeps;
                end else if (!open_reg) begin
                    timer_next      = '0;
                    phase_next      = PH_IDLE;
                    beeps_left_next = cfg.alarm_beeps;
                end
            end
            prev_buttons_next = item_buttons;
        end else if (item_en) begin
            seg_next        = seg_decode(digit_reg[scan_idx]);
            enable_next     = NUM_DISPLAYS'(3'b001 << scan_idx);
            disp_index_next = (scan_idx >= 2'd2) ? 2'd0 : scan_idx + 2'd1;

            if (beeps_left_reg != '0) begin
                timer_next = timer_inc;
                unique case (phase_reg)
                    PH_IDLE: begin
                        tone_next  = 1'b1;
                        phase_next = PH_TONE;
                        timer_next = '0;
                    end
                    PH_TONE: begin
                        if (timer_inc >= cfg.tone_ticks) begin
                            tone_next  = 1'b0;
                            phase_next = PH_PAUSE;
                            timer_next = '0;
                        end
                    end
                    PH_PAUSE: begin
                        if (timer_inc >= cfg.pause_ticks) begin
                            phase_next      = PH_IDLE;
                            timer_next      = '0;
                            beeps_left_next = beeps_left_reg - 4'd1;
                        end
                    end
                    default: timer_next = timer_inc;
                endcase
            end else begin
                tone_next  = 1'b0;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_DISPLAYS; k++) begin
                digit_reg[k] <= '0;
            end
            prev_buttons_reg <= '1;
            open_reg         <= 1'b0;
            disp_index_reg   <= '0;
            seg_reg          <= '0;
            enable_reg       <= '0;
            beeps_left_reg   <= '0;
            timer_reg        <= '0;
            phase_reg        <= PH_IDLE;
            tone_reg         <= 1'b0;
        end else begin
            for (int k = 0; k < NUM_DISPLAYS; k++) begin
                digit_reg[k] <= digit_next[k];
            end
            prev_buttons_reg <= prev_buttons_next;
            open_reg         <= open_next;
            disp_index_reg   <= disp_index_next;
            seg_reg          <= seg_next;
            enable_reg       <= enable_next;
            beeps_left_reg   <= beeps_left_next;
            timer_reg        <= timer_next;
            phase_reg        <= phase_next;
            tone_reg         <= tone_next;
        end
    end

    // The result is the state as it stands after the current word.
    assign result.segments       = seg_next;
    assign result.display_enable = enable_next;
    assign result.lock_open      = open_next;
    assign result.tone_on        = tone_next;

    a_tone_phase_has_beeps: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TONE |-> beeps_left_reg != '0)
        else $error("tone phase entered with no beeps left");

    a_tick_enables_one: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en && item_kind == KIND_TICK |=> $onehot(enable_reg))
        else $error("display scan did not select exactly one display");

    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_reg[0] <= 4'd9 && digit_reg[1] <= 4'd9 && digit_reg[2] <= 4'd9)
        else $error("entered digit left the decimal range");

endmodule

[rtl/combination_lock_controller_unit.sv]
// ----------------------------------------------------------------------------
// Combination lock controller unit
// Three-digit combination lock with display scan and beep sequencer.
// ----------------------------------------------------------------------------
// A word accepted into the input stage register moves on to the result stage register,
// which drives m_tdata. Throughput: one word per cycle while m_tready does not stall.
// The input and result registers form a two-stage pipeline; a new word is taken while a
// result waits on m_tready if the input stage is empty. The rate is set by the core update.
// Reset (aresetn low, synchronous) clears both pipeline stages, restores the
// register defaults (code 1-2-3, tone 200, pause 150, beeps 2/1/10) and closes the lock.
// ----------------------------------------------------------------------------
module combination_lock_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input stream: one word is either a millisecond tick or a button sample.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [3:0] buttons, [7:4] zero
    input  logic                                s_tuser,   // [0] kind

    // Result stream: one word per input word.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [6:0] segments,
                                                           // [9:7] display_enable,
                                                           // [10] lock_open, [11] tone_on,
                                                           // [15:12] zero

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import clc_pkg::*;

    // Input stage register.
    logic                in_valid_reg, in_valid_next;
    logic                in_kind_reg, in_kind_next;
    logic [BUTTON_W-1:0] in_buttons_reg, in_buttons_next;

    // Result stage register.
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg, out_data_next;

    logic                s_accept;
    logic                advance;
    cfg_t                cfg;
    result_t             core_result;

    // The configuration registers never stall a write.
    assign cfg_ready = 1'b1;

    // A word moves from the input stage to the result stage whenever the result
    // stage is empty or is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    clc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The core updates its state exactly when a word leaves the input stage.
    clc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_en      (advance),
        .item_kind    (in_kind_reg),
        .item_buttons (in_buttons_reg),
        .cfg          (cfg),
        .result       (core_result)
    );

    always_comb begin
        in_kind_next    = in_kind_reg;
        in_buttons_next = in_buttons_reg;
        if (s_accept) begin
            in_valid_next   = 1'b1;
            in_kind_next    = s_tuser;
            in_buttons_next = s_tdata[BUTTON_W-1:0];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        out_data_next = out_data_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = core_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_kind_reg    <= in_kind_next;
        in_buttons_reg <= in_buttons_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.tone_on, out_data_reg.lock_open,
                       out_data_reg.display_enable, out_data_reg.segments};

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

    a_result_from_input_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result appeared without a word in the input stage");

    a_enable_at_most_one: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0(out_data_reg.display_enable))
        else $error("more than one display enabled in a result word");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Combination lock controller testbench
// Drives ticks, button samples and register writes into the lock block,
// predicts every result word with an independent model of the lock, display
// scan and beep sequencer, and checks the result stream field by field.
// ----------------------------------------------------------------------------

class lock_scoreboard;
    // Register copies
    logic [3:0]  code [3];
    logic [15:0] tone_len;
    logic [15:0] pause_len;
    logic [3:0]  open_cnt;
    logic [3:0]  close_cnt;
    logic [3:0]  alarm_cnt;

    // Lock state
    logic [3:0]           digits [3];
    logic [3:0]           last_buttons;
    logic                 is_open;
    logic [1:0]           scan_pos;
    logic [6:0]           seg_q;
    logic [2:0]           enable_q;
    logic [3:0]           beeps_due;
    logic [15:0]          phase_ticks;
    clc_pkg::beep_phase_t phase;
    logic                 tone_q;

    clc_pkg::result_t expected_readouts [$];
    int               fail_count;

    function new();
        code[0]      = 4'd1;
        code[1]      = 4'd2;
        code[2]      = 4'd3;
        tone_len     = 16'd200;
        pause_len    = 16'd150;
        open_cnt     = 4'd2;
        close_cnt    = 4'd1;
        alarm_cnt    = 4'd10;
        digits[0]    = '0;
        digits[1]    = '0;
        digits[2]    = '0;
        last_buttons = 4'hF;
        is_open      = 1'b0;
        scan_pos     = '0;
        seg_q        = '0;
        enable_q     = '0;
        beeps_due    = '0;
        phase_ticks  = '0;
        phase        = clc_pkg::PH_IDLE;
        tone_q       = 1'b0;
        fail_count   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
        case (idx)
            clc_pkg::CFG_CODE_DIGIT_ZERO: code[0]   = value[3:0];
            clc_pkg::CFG_CODE_DIGIT_ONE:  code[1]   = value[3:0];
            clc_pkg::CFG_CODE_DIGIT_TWO:  code[2]   = value[3:0];
            clc_pkg::CFG_TONE_TICKS:      tone_len  = value;
            clc_pkg::CFG_PAUSE_TICKS:     pause_len = value;
            clc_pkg::CFG_OPEN_BEEPS:      open_cnt  = value[3:0];
            clc_pkg::CFG_CLOSE_BEEPS:     close_cnt = value[3:0];
            clc_pkg::CFG_ALARM_BEEPS:     alarm_cnt = value[3:0];
            default: ;
        endcase
    endfunction

    function logic [6:0] digit_pattern(logic [3:0] d);
        case (d)
            4'd0:    return 7'h7E;
            4'd1:    return 7'h30;
            4'd2:    return 7'h6D;
            4'd3:    return 7'h79;
            4'd4:    return 7'h33;
            4'd5:    return 7'h5B;
            4'd6:    return 7'h5F;
            4'd7:    return 7'h70;
            4'd8:    return 7'h7F;
            4'd9:    return 7'h7B;
            default: return 7'h00;
        endcase
    endfunction

    function void advance_tick();
        logic [1:0] pos;
        pos = scan_pos;
        if (pos > 2'd2) pos = 2'd0;
        seg_q    = digit_pattern(digits[pos]);
        enable_q = 3'b001 << pos;
        scan_pos = (pos >= 2'd2) ? 2'd0 : pos + 2'd1;
        if (beeps_due != 4'd0) begin
            phase_ticks = phase_ticks + 16'd1;
            if (phase == clc_pkg::PH_IDLE) begin
                tone_q      = 1'b1;
                phase       = clc_pkg::PH_TONE;
                phase_ticks = '0;
            end else if (phase == clc_pkg::PH_TONE && phase_ticks >= tone_len) begin
                tone_q      = 1'b0;
                phase       = clc_pkg::PH_PAUSE;
                phase_ticks = '0;
            end else if (phase == clc_pkg::PH_PAUSE && phase_ticks >= pause_len) begin
                phase       = clc_pkg::PH_IDLE;
                phase_ticks = '0;
                beeps_due   = beeps_due - 4'd1;
            end
        end else begin
            tone_q = 1'b0;
            phase  = clc_pkg::PH_IDLE;
        end
    endfunction

    function void apply_buttons(logic [3:0] now);
        logic [3:0] falls;
        logic       code_hit;
        int         k;
        falls = last_buttons & ~now;
        // Digit steps come first so that a confirm in the same sample sees them.
        for (k = 0; k < 3; k++) begin
            if (falls[k]) digits[k] = (digits[k] >= 4'd9) ? 4'd0 : digits[k] + 4'd1;
        end
        if (falls[clc_pkg::CONFIRM_BIT]) begin
            code_hit = (digits[0] == code[0]) && (digits[1] == code[1]) &&
                       (digits[2] == code[2]);
            if (code_hit) begin
                is_open     = ~is_open;
                phase_ticks = '0;
                phase       = clc_pkg::PH_IDLE;
                beeps_due   = is_open ? open_cnt : close_cnt;
            end else if (!is_open) begin
                phase_ticks = '0;
                phase       = clc_pkg::PH_IDLE;
                beeps_due   = alarm_cnt;
            end
        end
        last_buttons = now;
    endfunction

    function void note_word(logic kind, logic [3:0] buttons);
        clc_pkg::result_t r;
        if (kind == clc_pkg::KIND_BUTTON) apply_buttons(buttons);
        else advance_tick();
        r.segments       = seg_q;
        r.display_enable = enable_q;
        r.lock_open      = is_open;
        r.tone_on        = tone_q;
        expected_readouts.push_back(r);
    endfunction

    function void check_result(logic [15:0] word);
        clc_pkg::result_t got;
        clc_pkg::result_t want;
        got = word[11:0];
        if (expected_readouts.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result word %h", word);
            return;
        end
        want = expected_readouts.pop_front();
        if (got.segments !== want.segments ||
            got.display_enable !== want.display_enable ||
            got.lock_open !== want.lock_open || got.tone_on !== want.tone_on) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: segments %h/%h enable %b/%b open %b/%b tone %b/%b",
                         want.segments, got.segments, want.display_enable,
                         got.display_enable, want.lock_open, got.lock_open,
                         want.tone_on, got.tone_on);
        end
    endfunction

    function int pending();
        return expected_readouts.size();
    endfunction
endclass

module testbench;
    import clc_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_COUNT = 500;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lock_scoreboard lock_sb;
    int             sent_words;
    int             readouts_seen;
    logic           send_burst;

    combination_lock_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every driving task starts and ends at a falling edge.
    task automatic send_word(input logic kind, input logic [3:0] buttons);
        int gap;
        if (sent_words % 64 == 0) send_burst = ($urandom_range(0, 2) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, buttons};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        lock_sb.note_word(kind, buttons);
        sent_words++;
        @(negedge aclk);
    endtask

    // Ticks carry random button bits, which the block must ignore.
    task automatic send_tick();
        send_word(KIND_TICK, 4'($urandom_range(0, 15)));
    endtask

    task automatic press_key(input int key);
        send_word(KIND_BUTTON, 4'hF & ~(4'b0001 << key));
        repeat ($urandom_range(0, 1)) send_tick();
        send_word(KIND_BUTTON, 4'hF);
    endtask

    // Steps each entered digit up to its target, then presses confirm.
    task automatic enter_code(input logic [3:0] t0, input logic [3:0] t1,
                              input logic [3:0] t2);
        logic [3:0] target [3];
        int         k;
        int         steps;
        target[0] = t0;
        target[1] = t1;
        target[2] = t2;
        send_word(KIND_BUTTON, 4'hF);
        for (k = 0; k < 3; k++) begin
            if (target[k] > 4'd9) target[k] = 4'($urandom_range(0, 9));
            steps = (int'(target[k]) + 10 - int'(lock_sb.digits[k])) % 10;
            repeat (steps) press_key(k);
        end
        press_key(CONFIRM_BIT);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (lock_sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        lock_sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic load_settings(input cfg_t s);
        drain_results();
        write_reg(CFG_CODE_DIGIT_ZERO, 16'(s.code_digit_zero));
        write_reg(CFG_CODE_DIGIT_ONE,  16'(s.code_digit_one));
        write_reg(CFG_CODE_DIGIT_TWO,  16'(s.code_digit_two));
        write_reg(CFG_TONE_TICKS,      s.tone_ticks);
        write_reg(CFG_PAUSE_TICKS,     s.pause_ticks);
        write_reg(CFG_OPEN_BEEPS,      16'(s.open_beeps));
        write_reg(CFG_CLOSE_BEEPS,     16'(s.close_beeps));
        write_reg(CFG_ALARM_BEEPS,     16'(s.alarm_beeps));
        cfg_valid <= 1'b0;
    endtask

    // Mostly proper code entries (often the right code, so the lock toggles),
    // followed by tick runs for the beeper; the rest is tick runs, noise and half entries.
    task automatic run_random(input int words);
        int start;
        int pick;
        start = sent_words;
        while (sent_words - start < words) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 3) != 0)
                    enter_code(lock_sb.code[0], lock_sb.code[1], lock_sb.code[2]);
                else
                    enter_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                               4'($urandom_range(0, 9)));
                repeat ($urandom_range(5, 40)) send_tick();
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 20)) send_tick();
            end else if (pick < 76) begin
                repeat ($urandom_range(60, 150)) send_tick();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8))
                    send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end else begin
                repeat ($urandom_range(1, 4)) press_key($urandom_range(0, 3));
                send_word(KIND_BUTTON, 4'($urandom_range(0, 15)));
                send_word(KIND_BUTTON, 4'($urandom_range(0, 15)));
            end
        end
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.code_digit_zero = 4'($urandom_range(0, 9));
        s.code_digit_one  = 4'($urandom_range(0, 9));
        s.code_digit_two  = 4'($urandom_range(0, 9));
        s.tone_ticks      = 16'($urandom_range(1, 6));
        s.pause_ticks     = 16'($urandom_range(1, 6));
        s.open_beeps      = 4'($urandom_range(0, 15));
        s.close_beeps     = 4'($urandom_range(0, 15));
        s.alarm_beeps     = 4'($urandom_range(0, 15));
        return s;
    endfunction

    // Result side: random stalls, stretches without any, and one long hold
    // while the sender keeps offering, so the block backs up its input.
    initial begin
        int   gap;
        logic recv_burst;
        m_tready      <= 1'b0;
        readouts_seen = 0;
        recv_burst    = 1'b0;
        @(negedge aclk);
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if (readouts_seen % 64 == 0) recv_burst = ($urandom_range(0, 2) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 14);
            if (readouts_seen == HOLD_AT_COUNT) gap = gap + LONG_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            lock_sb.check_result(m_tdata);
            readouts_seen++;
            @(negedge aclk);
        end
    end

    // Ends the run if no word moves on any channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL combination_lock_controller_unit");
        $finish;
    end

    initial begin
        cfg_t s;
        lock_sb    = new();
        sent_words = 0;
        send_burst = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with the reset settings (code 1-2-3).
        repeat (4) send_tick();                 // full scan round and wrap
        send_word(KIND_BUTTON, 4'hF);           // no edges
        send_word(KIND_BUTTON, 4'h0);           // all edges: steps, then a wrong code
        send_tick();                            // alarm tone starts
        send_word(KIND_BUTTON, 4'hF);
        send_word(KIND_BUTTON, 4'b1101);        // digit one to 2
        send_word(KIND_BUTTON, 4'hF);
        send_word(KIND_BUTTON, 4'b1011);        // digit two to 2
        send_word(KIND_BUTTON, 4'hF);
        send_word(KIND_BUTTON, 4'b1011);        // digit two to 3
        send_word(KIND_BUTTON, 4'b0011);        // confirm with the right code: opens
        send_tick();
        send_word(KIND_BUTTON, 4'hF);
        send_word(KIND_BUTTON, 4'b1110);        // digit zero to 2
        send_word(KIND_BUTTON, 4'hF);
        send_word(KIND_BUTTON, 4'b0111);        // wrong code while open: no effect
        repeat (6) send_tick();
        run_random(150);

        // Low extremes, zero close and alarm beeps.
        s = '{code_digit_zero: 4'd0, code_digit_one: 4'd0, code_digit_two: 4'd0,
              tone_ticks: 16'd1, pause_ticks: 16'd1, open_beeps: 4'd15,
              close_beeps: 4'd0, alarm_beeps: 4'd0};
        load_settings(s);
        run_random(190);

        // High extremes.
        s = '{code_digit_zero: 4'd9, code_digit_one: 4'd9, code_digit_two: 4'd9,
              tone_ticks: 16'hFFFF, pause_ticks: 16'hFFFF, open_beeps: 4'd0,
              close_beeps: 4'd15, alarm_beeps: 4'd15};
        load_settings(s);
        run_random(190);

        // A code digit above nine never matches; zero tone and pause lengths.
        s = '{code_digit_zero: 4'd5, code_digit_one: 4'd12, code_digit_two: 4'd7,
              tone_ticks: 16'd0, pause_ticks: 16'd0, open_beeps: 4'd3,
              close_beeps: 4'd2, alarm_beeps: 4'd1};
        load_settings(s);
        run_random(190);

        load_settings(random_settings());
        run_random(95);
        drain_results();                        // sender waits for every result
        run_random(95);

        load_settings(random_settings());
        run_random(190);

        load_settings(random_settings());
        run_random(190);

        drain_results();
        repeat (10) @(negedge aclk);
        if (lock_sb.fail_count == 0 && lock_sb.pending() == 0)
            $display("PASS combination_lock_controller_unit");
        else
            $display("FAIL combination_lock_controller_unit");
        $finish;
    end

endmodule
